### hdl/trp_pkg.sv
// Shared types, constants and command codes for the retransmission pool.
package trp_pkg;
   localparam int PoolEntriesDefault = 12;
   localparam int SocketsDefault     = 4;
   localparam logic [31:0] SeqWindow   = 32'd1000000;
   localparam logic [31:0] Never       = 32'hFFFF_FFFF;
   localparam logic [31:0] BaseReset   = 32'd1000000;
   localparam logic [3:0]  LimitReset  = 4'd5;
   localparam logic [4:0]  CountMax    = 5'd31;
   localparam logic [4:0]  RetryMax    = 5'd31;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_ACK   = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_PURGE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_ADDED = 3'd1,
      KIND_FULL  = 3'd2,
      KIND_FREE  = 3'd3,
      KIND_RETX  = 3'd4,
      KIND_ABORT = 3'd5
   } kind_type;

   localparam logic CSR_BASE  = 1'b0;
   localparam logic CSR_LIMIT = 1'b1;

   typedef struct packed {
      cmd_type     cmd;
      logic [1:0]  socket;
      logic        sock_ok;
      logic [7:0]  packet;
      logic [15:0] length;
      logic [31:0] seq;
      logic [31:0] seq_end;
      logic [31:0] ack_number;
      logic [31:0] now;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ADD,
      ST_RETX,
      ST_ABORT,
      ST_SWEEP,
      ST_DONE
   } state_type;

   function automatic logic covers(logic [31:0] ack, logic [31:0] fin);
      logic [31:0] d;
      begin
         d = ack - fin;
         if (ack >= fin) covers = d <= SeqWindow;
         else            covers = (fin - ack) > SeqWindow;
      end
   endfunction
endpackage

### hdl/tcp_retransmit_pool_top.sv
// Top level of the TCP retransmission pool.
//  channel | ports                         | handshake
//  req     | req_command .. req_now        | start high while busy low
//  rsp     | rsp_kind .. rsp_last          | rsp_valid strobe, one cycle
//  csr     | csr_write, csr_index, csr_data| csr_write strobe
// A command is registered in the front queue and the back part takes it in the cycle after acceptance.
// An add's word passes the front queue, the ADD state, the hold register and the output
// register before it reaches the result ports; the next command can follow once busy falls.
// Acknowledge and purge on a valid socket, and tick, walk the entries one entry per clock;
// a tick stops its walk at the first entry over the retry limit, and that abort adds a
// second walk that frees every entry of the aborted socket.
// Reset frees every entry and clears the socket counters at once.
// The receiver cannot stall; busy stays high until the final word has left the ports.
module tcp_retransmit_pool_top #(
   parameter int POOL_ENTRIES = trp_pkg::PoolEntriesDefault,
   parameter int SOCKETS      = trp_pkg::SocketsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [1:0]  req_socket,
   input  logic [7:0]  req_packet,
   input  logic [15:0] req_length,
   input  logic [31:0] req_seq,
   input  logic [16:0] req_seq_span,
   input  logic [31:0] req_ack_number,
   input  logic [31:0] req_now,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [31:0] csr_data,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [1:0]  rsp_out_socket,
   output logic [7:0]  rsp_out_packet,
   output logic [15:0] rsp_out_length,
   output logic [31:0] rsp_out_seq,
   output logic [3:0]  rsp_slot,
   output logic        rsp_queued,
   output logic        rsp_last
);
   import trp_pkg::*;
   logic [31:0] base_ff;
   logic [3:0]  limit_ff;
   logic        full, job_valid, take, active;
   job_type     job;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BaseReset;
         limit_ff <= LimitReset;
      end else if (csr_write) begin
         if (csr_index == CSR_BASE)  base_ff  <= csr_data;
         if (csr_index == CSR_LIMIT) limit_ff <= csr_data[3:0];
      end
   end

   assign busy = full || active;

   trp_front #(.SOCKETS(SOCKETS)) u_front (
      .clock, .reset, .start(start && !busy), .cmd(req_command),
      .socket(req_socket), .packet(req_packet), .length(req_length),
      .seq(req_seq), .seq_span(req_seq_span), .ack_number(req_ack_number),
      .now(req_now), .take, .full, .job_valid, .job
   );

   trp_back #(.POOL_ENTRIES(POOL_ENTRIES), .SOCKETS(SOCKETS)) u_back (
      .clock, .reset, .job_valid, .job, .base_timeout(base_ff),
      .retry_limit(limit_ff), .take, .active, .rsp_valid, .rsp_kind,
      .rsp_out_socket, .rsp_out_packet, .rsp_out_length, .rsp_out_seq,
      .rsp_slot, .rsp_queued, .rsp_last
   );

   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid) else $error("last without valid");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start not taken");
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind <= 3'd5) else $error("bad kind");
endmodule

### hdl/trp_front.sv
// Front part: accepts commands, classifies them and queues them for execution.
module trp_front #(
   parameter int SOCKETS = trp_pkg::SocketsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          cmd,
   input  logic [1:0]          socket,
   input  logic [7:0]          packet,
   input  logic [15:0]         length,
   input  logic [31:0]         seq,
   input  logic [16:0]         seq_span,
   input  logic [31:0]         ack_number,
   input  logic [31:0]         now,
   input  logic                take,
   output logic                full,
   output logic                job_valid,
   output trp_pkg::job_type    job
);
   import trp_pkg::*;
   logic    q_valid_ff, q_valid_in;
   job_type q_ff, q_in;

   always_comb begin
      q_valid_in = q_valid_ff;
      q_in       = q_ff;
      if (take) q_valid_in = 1'b0;
      if (start && !q_valid_ff) begin
         q_valid_in    = 1'b1;
         q_in.cmd      = cmd_type'(cmd);
         q_in.socket   = socket;
         q_in.sock_ok  = 32'(socket) < SOCKETS;
         q_in.packet   = packet;
         q_in.length   = length;
         q_in.seq      = seq;
         q_in.seq_end  = seq + {15'd0, seq_span};
         q_in.ack_number = ack_number;
         q_in.now      = now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) q_valid_ff <= 1'b0;
      else       q_valid_ff <= q_valid_in;
      q_ff <= q_in;
   end

   assign full      = q_valid_ff;
   assign job_valid = q_valid_ff;
   assign job       = q_ff;
endmodule

### hdl/trp_back.sv
// Back part: walks the pool entry by entry and emits result words.
module trp_back #(
   parameter int POOL_ENTRIES = trp_pkg::PoolEntriesDefault,
   parameter int SOCKETS      = trp_pkg::SocketsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  trp_pkg::job_type    job,
   input  logic [31:0]         base_timeout,
   input  logic [3:0]          retry_limit,
   output logic                take,
   output logic                active,
   output logic                rsp_valid,
   output logic [2:0]          rsp_kind,
   output logic [1:0]          rsp_out_socket,
   output logic [7:0]          rsp_out_packet,
   output logic [15:0]         rsp_out_length,
   output logic [31:0]         rsp_out_seq,
   output logic [3:0]          rsp_slot,
   output logic                rsp_queued,
   output logic                rsp_last
);
   import trp_pkg::*;
   localparam int IW = $clog2(POOL_ENTRIES);
   localparam int SW = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;
   localparam logic [IW-1:0] LastIdx = IW'(POOL_ENTRIES - 1);

   typedef struct packed {
      kind_type    kind;
      logic [1:0]  socket;
      logic [7:0]  packet;
      logic [15:0] length;
      logic [31:0] seq;
      logic [3:0]  slot;
      logic        queued;
   } word_type;

   logic [7:0]  pkt_mem   [POOL_ENTRIES];
   logic [15:0] len_mem   [POOL_ENTRIES];
   logic [31:0] seq_mem   [POOL_ENTRIES];
   logic [31:0] end_mem   [POOL_ENTRIES];
   logic [31:0] dl_mem    [POOL_ENTRIES];
   logic [4:0]  rt_mem    [POOL_ENTRIES];

   logic [POOL_ENTRIES-1:0] used_ff, used_in;
   logic [1:0]  owner_ff [POOL_ENTRIES];
   logic [1:0]  owner_in [POOL_ENTRIES];
   logic [4:0]  cnt_ff [SOCKETS];
   logic [4:0]  cnt_in [SOCKETS];

   state_type     st_ff, st_in;
   job_type       j_ff, j_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [1:0]    abs_ff, abs_in;

   logic [7:0]    pkt_rd_ff;
   logic [15:0]   len_rd_ff;
   logic [31:0]   seq_rd_ff, end_rd_ff, dl_rd_ff;
   logic [4:0]    rt_rd_ff;

   logic [IW-1:0] free_ix;
   logic          free_found;
   logic [4:0]    rt_bump;
   logic [63:0]   shifted;
   logic [32:0]   sum;
   logic [31:0]   newdl;
   logic [32:0]   add_sum;
   logic [31:0]   add_dl;
   logic [SW-1:0] jsock;
   logic          hit;
   logic          wr_add, wr_retx;

   logic          o_v;
   word_type      o_w;
   logic          h_v_ff, h_v_in;
   word_type      h_w_ff, h_w_in;
   logic          out_v_ff, out_v_in;
   logic          out_last_ff, out_last_in;
   word_type      out_w_ff, out_w_in;

   assign jsock = SW'(j_ff.socket);

   always_comb begin
      free_found = 1'b0;
      free_ix    = '0;
      for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_ix    = IW'(i);
         end
      end
   end

   always_comb begin
      rt_bump = (rt_rd_ff < RetryMax) ? rt_rd_ff + 5'd1 : rt_rd_ff;
      shifted = {32'd0, base_timeout} << rt_bump;
      sum     = {1'b0, j_ff.now} + {1'b0, shifted[31:0]};
      newdl   = (shifted[63:32] != 32'd0 || sum[32]) ? Never : sum[31:0];
   end

   always_comb begin
      add_sum = {1'b0, j_ff.now} + {1'b0, base_timeout};
      add_dl  = (cnt_ff[jsock] >= 5'd2) ? Never : (add_sum[32] ? Never : add_sum[31:0]);
   end

   always_comb begin
      st_in    = st_ff;
      j_in     = j_ff;
      idx_in   = idx_ff;
      abs_in   = abs_ff;
      used_in  = used_ff;
      owner_in = owner_ff;
      cnt_in   = cnt_ff;
      take     = 1'b0;
      wr_add   = 1'b0;
      wr_retx  = 1'b0;
      hit      = 1'b0;
      o_v      = 1'b0;
      o_w      = '0;
      unique case (st_ff)
         ST_IDLE: begin
            if (job_valid) begin
               take   = 1'b1;
               j_in   = job;
               idx_in = '0;
               if (job.cmd == CMD_ADD && job.sock_ok) st_in = ST_ADD;
               else if (job.cmd == CMD_TICK || job.sock_ok) st_in = ST_SCAN;
               else st_in = ST_DONE;
            end
         end
         ST_ADD: begin
            o_v        = 1'b1;
            o_w.socket = j_ff.socket;
            o_w.packet = j_ff.packet;
            if (!free_found) begin
               o_w.kind = KIND_FULL;
            end else begin
               o_w.kind   = KIND_ADDED;
               o_w.length = j_ff.length;
               o_w.seq    = j_ff.seq;
               o_w.slot   = 4'(free_ix);
               o_w.queued = cnt_ff[jsock] >= 5'd2;
               wr_add = 1'b1;
               used_in[free_ix]  = 1'b1;
               owner_in[free_ix] = j_ff.socket;
               if (cnt_ff[jsock] < CountMax) cnt_in[jsock] = cnt_ff[jsock] + 5'd1;
            end
            st_in = ST_DONE;
         end
         ST_SCAN: begin
            unique case (j_ff.cmd)
               CMD_TICK: hit = used_ff[idx_ff] && (j_ff.now > dl_rd_ff);
               CMD_ACK:  hit = used_ff[idx_ff] && owner_ff[idx_ff] == j_ff.socket
                               && covers(j_ff.ack_number, end_rd_ff);
               default:  hit = used_ff[idx_ff] && owner_ff[idx_ff] == j_ff.socket;
            endcase
            if (hit) begin
               o_v        = 1'b1;
               o_w.socket = owner_ff[idx_ff];
               o_w.packet = pkt_rd_ff;
               if (j_ff.cmd == CMD_TICK) begin
                  o_w.kind   = KIND_RETX;
                  o_w.length = len_rd_ff;
                  o_w.seq    = seq_rd_ff;
                  if (rt_rd_ff > {1'b0, retry_limit}) begin
                     abs_in = owner_ff[idx_ff];
                     st_in  = ST_ABORT;
                  end else begin
                     wr_retx = 1'b1;
                  end
               end else begin
                  o_w.kind = KIND_FREE;
                  used_in[idx_ff] = 1'b0;
                  if (j_ff.cmd == CMD_ACK && cnt_ff[jsock] != 5'd0)
                     cnt_in[jsock] = cnt_ff[jsock] - 5'd1;
               end
            end
            if (st_in == ST_SCAN) begin
               if (idx_ff == LastIdx) begin
                  if (j_ff.cmd == CMD_PURGE) cnt_in[jsock] = '0;
                  st_in = ST_DONE;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         ST_ABORT: begin
            o_v        = 1'b1;
            o_w.kind   = KIND_ABORT;
            o_w.socket = abs_ff;
            idx_in = '0;
            st_in  = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (used_ff[idx_ff] && owner_ff[idx_ff] == abs_ff) begin
               o_v        = 1'b1;
               o_w.kind   = KIND_FREE;
               o_w.socket = abs_ff;
               o_w.packet = pkt_rd_ff;
               used_in[idx_ff] = 1'b0;
            end
            if (idx_ff == LastIdx) begin
               cnt_in[SW'(abs_ff)] = '0;
               st_in = ST_DONE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_DONE: begin
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // Each word waits in the hold register until the next word or the end of the
   // command shows whether it is the last one.
   always_comb begin
      h_v_in      = h_v_ff;
      h_w_in      = h_w_ff;
      out_v_in    = 1'b0;
      out_last_in = 1'b0;
      out_w_in    = out_w_ff;
      if (o_v) begin
         h_v_in = 1'b1;
         h_w_in = o_w;
         if (h_v_ff) begin
            out_v_in = 1'b1;
            out_w_in = h_w_ff;
         end
      end else if (st_ff == ST_DONE) begin
         h_v_in      = 1'b0;
         out_v_in    = 1'b1;
         out_last_in = 1'b1;
         out_w_in    = h_v_ff ? h_w_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_IDLE;
         used_ff     <= '0;
         for (int s = 0; s < SOCKETS; s++) cnt_ff[s] <= '0;
         idx_ff      <= '0;
         h_v_ff      <= 1'b0;
         out_v_ff    <= 1'b0;
         out_last_ff <= 1'b0;
      end else begin
         st_ff       <= st_in;
         used_ff     <= used_in;
         cnt_ff      <= cnt_in;
         idx_ff      <= idx_in;
         h_v_ff      <= h_v_in;
         out_v_ff    <= out_v_in;
         out_last_ff <= out_last_in;
      end
      owner_ff <= owner_in;
      j_ff     <= j_in;
      abs_ff   <= abs_in;
      h_w_ff   <= h_w_in;
      out_w_ff <= out_w_in;
      if (wr_add) begin
         pkt_mem[free_ix] <= j_ff.packet;
         len_mem[free_ix] <= j_ff.length;
         seq_mem[free_ix] <= j_ff.seq;
         end_mem[free_ix] <= j_ff.seq_end;
         dl_mem[free_ix]  <= add_dl;
         rt_mem[free_ix]  <= '0;
      end
      if (wr_retx) begin
         rt_mem[idx_ff] <= rt_bump;
         dl_mem[idx_ff] <= newdl;
      end
      pkt_rd_ff <= pkt_mem[idx_in];
      len_rd_ff <= len_mem[idx_in];
      seq_rd_ff <= seq_mem[idx_in];
      end_rd_ff <= end_mem[idx_in];
      dl_rd_ff  <= dl_mem[idx_in];
      rt_rd_ff  <= rt_mem[idx_in];
   end

   assign active         = (st_ff != ST_IDLE) || out_v_ff;
   assign rsp_valid      = out_v_ff;
   assign rsp_kind       = out_w_ff.kind;
   assign rsp_out_socket = out_w_ff.socket;
   assign rsp_out_packet = out_w_ff.packet;
   assign rsp_out_length = out_w_ff.length;
   assign rsp_out_seq    = out_w_ff.seq;
   assign rsp_slot       = out_w_ff.slot;
   assign rsp_queued     = out_w_ff.queued;
   assign rsp_last       = out_last_ff;
endmodule
